// ----- hdl/triangle_plane_clipper_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the triangle plane clipper
// Shorthand for clocked implication checks, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_CLIPPER_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold in the same cycle
`define TPC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: when pre holds, post must hold in the next cycle
`define TPC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle plane clipper package
// Shared constants, register indexes and control types.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Normal components are Q2.16 in 18 bits
    localparam int NORMAL_BITS = 18;
    localparam int FRAC_BITS   = 16;
    // Distance width beyond the coordinate width: diff sign bit, normal, sum growth, minus fraction
    localparam int DIST_EXTRA  = 3 + NORMAL_BITS - FRAC_BITS;

    // Quotient bits resolved in each divider stage
    localparam int DIV_STEPS = 2;

    // Stage counts of the distance and setup sections
    localparam int DIST_LAT  = 3;
    localparam int SETUP_LAT = 3;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_Z = 3'd5;

    // How a triangle splits against the plane
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ALL,
        KIND_ONE,
        KIND_TWO
    } kind_t;

    // Control handed from the setup section to the divider lanes and emit stage
    typedef struct packed {
        kind_t           kind;
        logic [1:0][2:0] neg;
    } tpc_ctl_t;

endpackage

// ----- hdl/triangle_plane_clipper.sv -----
// ----------------------------------------------------------------------------
// Triangle plane clipper
// Clips one triangle per transaction against a configured plane; zero, one
// or two triangles come out.
// ----------------------------------------------------------------------------
// A triangle is taken on a rising edge with start high and busy low, and a
// new one may follow on every cycle in which busy is low. Its results pass
// through the distance and setup stages and the divider lanes, which resolve
// two quotient bits per stage. Each result is shown for exactly one cycle
// with out_valid high; the receiver cannot hold it off. A triangle that
// splits into two results shows the first of them while busy is high,
// which holds off input, and then the second. Triangles fully outside
// give no result. Write configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "triangle_plane_clipper_macros.svh"

module triangle_plane_clipper #(
    parameter int COORD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      a_x,
    input  logic signed [COORD_BITS-1:0]      a_y,
    input  logic signed [COORD_BITS-1:0]      a_z,
    input  logic signed [COORD_BITS-1:0]      b_x,
    input  logic signed [COORD_BITS-1:0]      b_y,
    input  logic signed [COORD_BITS-1:0]      b_z,
    input  logic signed [COORD_BITS-1:0]      c_x,
    input  logic signed [COORD_BITS-1:0]      c_y,
    input  logic signed [COORD_BITS-1:0]      c_z,
    input  logic [7:0]                        shade,
    input  logic [15:0]                       tag,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [((COORD_BITS > tpc_pkg::NORMAL_BITS) ?
                   COORD_BITS : tpc_pkg::NORMAL_BITS)-1:0] cfg_data,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      out_a_x,
    output logic signed [COORD_BITS-1:0]      out_a_y,
    output logic signed [COORD_BITS-1:0]      out_a_z,
    output logic signed [COORD_BITS-1:0]      out_b_x,
    output logic signed [COORD_BITS-1:0]      out_b_y,
    output logic signed [COORD_BITS-1:0]      out_b_z,
    output logic signed [COORD_BITS-1:0]      out_c_x,
    output logic signed [COORD_BITS-1:0]      out_c_y,
    output logic signed [COORD_BITS-1:0]      out_c_z,
    output logic [7:0]                        out_shade,
    output logic [15:0]                       out_tag,
    output logic                              last
);

    localparam int CW      = COORD_BITS;
    localparam int NB      = tpc_pkg::NORMAL_BITS;
    localparam int DISTW   = CW + tpc_pkg::DIST_EXTRA;
    localparam int NW      = 2 * CW + tpc_pkg::DIST_EXTRA;
    localparam int MW      = CW + 1;
    localparam int NST     = (MW + tpc_pkg::DIV_STEPS - 1) / tpc_pkg::DIV_STEPS;
    localparam int DIV_LAT = NST + 1;
    localparam int SB_LAT  = tpc_pkg::DIST_LAT + tpc_pkg::SETUP_LAT + DIV_LAT;

    // Configuration
    logic signed [CW-1:0] plane_point_x_reg;
    logic signed [CW-1:0] plane_point_y_reg;
    logic signed [CW-1:0] plane_point_z_reg;
    logic signed [NB-1:0] normal_x_reg;
    logic signed [NB-1:0] normal_y_reg;
    logic signed [NB-1:0] normal_z_reg;
    logic signed [CW-1:0] point [3];
    logic signed [NB-1:0] normal [3];

    // Stall control
    logic                 hold;
    logic                 en;
    logic                 phase_reg;

    // Input stage
    logic                 in_valid_reg;
    logic signed [CW-1:0] in_vert_reg [3][3];
    logic [7:0]           in_shade_reg;
    logic [15:0]          in_tag_reg;

    // Section outputs
    logic signed [CW-1:0]    dist_vert [3][3];
    logic signed [DISTW-1:0] dist_val [3];
    tpc_pkg::tpc_ctl_t       setup_ctl;
    logic signed [CW-1:0]    setup_vert [3][3];
    logic [NW-1:0]           setup_prod [2][3];
    logic [DISTW-1:0]        setup_den [2];
    logic signed [CW-1:0]    lane_x [2][3];

    // Side chains
    logic [SB_LAT-1:0]       sb_valid_reg;
    logic [7:0]              sb_shade_reg [SB_LAT];
    logic [15:0]             sb_tag_reg [SB_LAT];
    tpc_pkg::kind_t          kc_kind_reg [DIV_LAT];
    logic signed [CW-1:0]    kc_vert_reg [DIV_LAT][3][3];

    // Emit stage view
    logic                    e_valid;
    tpc_pkg::kind_t          e_kind;
    logic signed [CW-1:0]    oa [3];
    logic signed [CW-1:0]    ob [3];
    logic signed [CW-1:0]    oc [3];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_point_x_reg <= '0;
            plane_point_y_reg <= '0;
            plane_point_z_reg <= CW'(6554);
            normal_x_reg      <= '0;
            normal_y_reg      <= '0;
            normal_z_reg      <= NB'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpc_pkg::REG_PLANE_X:  plane_point_x_reg <= cfg_data[CW-1:0];
                tpc_pkg::REG_PLANE_Y:  plane_point_y_reg <= cfg_data[CW-1:0];
                tpc_pkg::REG_PLANE_Z:  plane_point_z_reg <= cfg_data[CW-1:0];
                tpc_pkg::REG_NORMAL_X: normal_x_reg      <= cfg_data[NB-1:0];
                tpc_pkg::REG_NORMAL_Y: normal_y_reg      <= cfg_data[NB-1:0];
                tpc_pkg::REG_NORMAL_Z: normal_z_reg      <= cfg_data[NB-1:0];
                default: ;
            endcase
        end
    end

    assign point[0]  = plane_point_x_reg;
    assign point[1]  = plane_point_y_reg;
    assign point[2]  = plane_point_z_reg;
    assign normal[0] = normal_x_reg;
    assign normal[1] = normal_y_reg;
    assign normal[2] = normal_z_reg;

    // Hold the whole pipe while the first of two results is shown
    assign e_valid = sb_valid_reg[SB_LAT-1];
    assign e_kind  = kc_kind_reg[DIV_LAT-1];
    assign hold    = e_valid && (e_kind == tpc_pkg::KIND_TWO) && !phase_reg;
    assign en      = !hold;
    assign busy    = hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            in_valid_reg <= 1'b0;
            sb_valid_reg <= '0;
        end
        else
        begin
            phase_reg <= hold;
            if (en)
            begin
                in_valid_reg <= start;
                sb_valid_reg <= {sb_valid_reg[SB_LAT-2:0], in_valid_reg};
            end
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_vert_reg[0][0] <= a_x;
            in_vert_reg[0][1] <= a_y;
            in_vert_reg[0][2] <= a_z;
            in_vert_reg[1][0] <= b_x;
            in_vert_reg[1][1] <= b_y;
            in_vert_reg[1][2] <= b_z;
            in_vert_reg[2][0] <= c_x;
            in_vert_reg[2][1] <= c_y;
            in_vert_reg[2][2] <= c_z;
            in_shade_reg      <= shade;
            in_tag_reg        <= tag;
        end
    end

    tpc_dist #(
        .CW (CW)
    ) u_dist (
        .clk      (clk),
        .en       (en),
        .vert     (in_vert_reg),
        .point    (point),
        .normal   (normal),
        .vert_out (dist_vert),
        .dval     (dist_val)
    );

    tpc_setup #(
        .CW (CW)
    ) u_setup (
        .clk   (clk),
        .en    (en),
        .vert  (dist_vert),
        .dval  (dist_val),
        .ctl   (setup_ctl),
        .rvert (setup_vert),
        .prod  (setup_prod),
        .den   (setup_den)
    );

    // One divider lane per intersection coordinate
    for (genvar k = 0; k < 2; k++)
    begin : g_cut
        for (genvar c = 0; c < 3; c++)
        begin : g_coord
            logic signed [CW-1:0] lane_base;

            // Second cut starts at the second inside vertex when two are inside
            if (k == 0)
            begin : g_first
                assign lane_base = setup_vert[0][c];
            end
            else
            begin : g_second
                assign lane_base = (setup_ctl.kind == tpc_pkg::KIND_TWO) ?
                                   setup_vert[1][c] : setup_vert[0][c];
            end

            tpc_div #(
                .CW (CW)
            ) u_div (
                .clk  (clk),
                .en   (en),
                .prod (setup_prod[k][c]),
                .den  (setup_den[k]),
                .neg  (setup_ctl.neg[k][c]),
                .base (lane_base),
                .x    (lane_x[k][c])
            );
        end
    end

    // Carry shade, tag, kind and kept vertices alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_shade_reg[0] <= in_shade_reg;
            sb_tag_reg[0]   <= in_tag_reg;
            for (int i = 1; i < SB_LAT; i++)
            begin
                sb_shade_reg[i] <= sb_shade_reg[i-1];
                sb_tag_reg[i]   <= sb_tag_reg[i-1];
            end
            kc_kind_reg[0] <= setup_ctl.kind;
            kc_vert_reg[0] <= setup_vert;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                kc_kind_reg[i] <= kc_kind_reg[i-1];
                kc_vert_reg[i] <= kc_vert_reg[i-1];
            end
        end
    end

    // Assemble the triangle shown this cycle
    always_comb
    begin
        oa   = kc_vert_reg[DIV_LAT-1][0];
        ob   = kc_vert_reg[DIV_LAT-1][1];
        oc   = kc_vert_reg[DIV_LAT-1][2];
        last = 1'b0;
        unique case (e_kind)
            tpc_pkg::KIND_NONE: last = 1'b0;
            tpc_pkg::KIND_ALL:  last = 1'b1;
            tpc_pkg::KIND_ONE:
            begin
                ob   = lane_x[0];
                oc   = lane_x[1];
                last = 1'b1;
            end
            tpc_pkg::KIND_TWO:
            begin
                if (phase_reg)
                begin
                    oa   = kc_vert_reg[DIV_LAT-1][1];
                    ob   = lane_x[0];
                    oc   = lane_x[1];
                    last = 1'b1;
                end
                else
                begin
                    oc   = lane_x[0];
                    last = 1'b0;
                end
            end
        endcase
    end

    assign out_valid = e_valid && (e_kind != tpc_pkg::KIND_NONE);
    assign out_a_x   = oa[0];
    assign out_a_y   = oa[1];
    assign out_a_z   = oa[2];
    assign out_b_x   = ob[0];
    assign out_b_y   = ob[1];
    assign out_b_z   = ob[2];
    assign out_c_x   = oc[0];
    assign out_c_y   = oc[1];
    assign out_c_z   = oc[2];
    assign out_shade = sb_shade_reg[SB_LAT-1];
    assign out_tag   = sb_tag_reg[SB_LAT-1];

    // Checks on the split-result sequence
    `TPC_ASSERT_NEXT(a_hold_one_cycle, busy, !busy, "busy lasted more than one cycle")
    `TPC_ASSERT_SAME(a_hold_first_half, busy, out_valid && !last,
                     "busy without the first of a result pair")
    `TPC_ASSERT_NEXT(a_hold_then_last, busy, out_valid && last,
                     "second result of a pair missing after busy")
    `TPC_ASSERT_SAME(a_not_last_holds, out_valid && !last, busy,
                     "non-final result shown without holding input")

endmodule

// ----- hdl/tpc_dist.sv -----
// ----------------------------------------------------------------------------
// Signed plane distance
// Three stages: vertex minus plane point, times normal, then sum and floor.
// ----------------------------------------------------------------------------
module tpc_dist #(
    parameter int CW = 32
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [CW-1:0]                  vert [3][3],
    input  logic signed [CW-1:0]                  point [3],
    input  logic signed [tpc_pkg::NORMAL_BITS-1:0] normal [3],
    output logic signed [CW-1:0]                  vert_out [3][3],
    output logic signed [CW+tpc_pkg::DIST_EXTRA-1:0] dval [3]
);

    localparam int DW    = CW + 1;
    localparam int PW    = DW + tpc_pkg::NORMAL_BITS;
    localparam int SW    = PW + 2;
    localparam int DISTW = CW + tpc_pkg::DIST_EXTRA;

    logic signed [DW-1:0]    diff_next [3][3];
    logic signed [DW-1:0]    diff_reg  [3][3];
    logic signed [PW-1:0]    prod_next [3][3];
    logic signed [PW-1:0]    prod_reg  [3][3];
    logic signed [SW-1:0]    sum       [3];
    logic signed [DISTW-1:0] dval_next [3];
    logic signed [DISTW-1:0] dval_reg  [3];
    logic signed [CW-1:0]    vert1_reg [3][3];
    logic signed [CW-1:0]    vert2_reg [3][3];
    logic signed [CW-1:0]    vert3_reg [3][3];

    // Subtract, multiply, sum and drop the fraction (floor)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                diff_next[i][k] = DW'(vert[i][k]) - DW'(point[k]);
                prod_next[i][k] = PW'(diff_reg[i][k]) * PW'(normal[k]);
            end
            sum[i] = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
            dval_next[i] = sum[i][SW-1:tpc_pkg::FRAC_BITS];
        end
    end

    // Advance the three stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg  <= diff_next;
            prod_reg  <= prod_next;
            dval_reg  <= dval_next;
            vert1_reg <= vert;
            vert2_reg <= vert1_reg;
            vert3_reg <= vert2_reg;
        end
    end

    assign vert_out = vert3_reg;
    assign dval     = dval_reg;

endmodule

// ----- hdl/tpc_setup.sv -----
// ----------------------------------------------------------------------------
// Clip setup
// Classifies vertices, picks edge endpoints, and forms |E-S| * ds for each
// intersection coordinate as two partial products joined in a third stage.
// ----------------------------------------------------------------------------
module tpc_setup #(
    parameter int CW = 32
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [CW-1:0]                     vert [3][3],
    input  logic signed [CW+tpc_pkg::DIST_EXTRA-1:0] dval [3],
    output tpc_pkg::tpc_ctl_t                        ctl,
    output logic signed [CW-1:0]                     rvert [3][3],
    output logic [2*CW+tpc_pkg::DIST_EXTRA-1:0]      prod [2][3],
    output logic [CW+tpc_pkg::DIST_EXTRA-1:0]        den [2]
);

    localparam int MW    = CW + 1;
    localparam int DISTW = CW + tpc_pkg::DIST_EXTRA;
    localparam int DSW   = DISTW - 1;
    localparam int NW    = MW + DSW;
    localparam int LO    = 18;
    localparam int HI    = DSW - LO;

    // Selection
    logic [2:0]            flags;
    tpc_pkg::kind_t        kind_next;
    logic [1:0]            si [2];
    logic [1:0]            ei [2];
    logic [1:0]            ri0;
    logic [1:0]            ri1;

    // Stage 4
    tpc_pkg::kind_t        kind4_reg;
    logic signed [CW-1:0]  r4_reg [3][3];
    logic signed [MW-1:0]  delta_next [2][3];
    logic signed [MW-1:0]  delta4_reg [2][3];
    logic [DSW-1:0]        ds4_reg [2];
    logic [DISTW-1:0]      den_next [2];
    logic [DISTW-1:0]      den4_reg [2];

    // Stage 5
    logic [MW-1:0]         mag [2][3];
    logic [MW+LO-1:0]      plo_next [2][3];
    logic [MW+HI-1:0]      phi_next [2][3];
    tpc_pkg::kind_t        kind5_reg;
    logic signed [CW-1:0]  r5_reg [3][3];
    logic [1:0][2:0]       neg5_reg;
    logic [MW+LO-1:0]      plo5_reg [2][3];
    logic [MW+HI-1:0]      phi5_reg [2][3];
    logic [DISTW-1:0]      den5_reg [2];

    // Stage 6
    logic [NW-1:0]         prod_next [2][3];
    tpc_pkg::kind_t        kind6_reg;
    logic signed [CW-1:0]  r6_reg [3][3];
    logic [1:0][2:0]       neg6_reg;
    logic [NW-1:0]         prod6_reg [2][3];
    logic [DISTW-1:0]      den6_reg [2];

    // Classify by inside flags and pick start and end of each cut edge
    always_comb
    begin
        flags = {~dval[2][DISTW-1], ~dval[1][DISTW-1], ~dval[0][DISTW-1]};
        kind_next = tpc_pkg::KIND_NONE;
        si[0] = 2'd0;
        si[1] = 2'd0;
        ei[0] = 2'd1;
        ei[1] = 2'd2;
        ri0   = 2'd0;
        ri1   = 2'd1;
        unique case (flags)
            3'b000: kind_next = tpc_pkg::KIND_NONE;
            3'b111: kind_next = tpc_pkg::KIND_ALL;
            3'b001:
            begin
                kind_next = tpc_pkg::KIND_ONE;
                si[0] = 2'd0; si[1] = 2'd0; ei[0] = 2'd1; ei[1] = 2'd2; ri0 = 2'd0;
            end
            3'b010:
            begin
                kind_next = tpc_pkg::KIND_ONE;
                si[0] = 2'd1; si[1] = 2'd1; ei[0] = 2'd0; ei[1] = 2'd2; ri0 = 2'd1;
            end
            3'b100:
            begin
                kind_next = tpc_pkg::KIND_ONE;
                si[0] = 2'd2; si[1] = 2'd2; ei[0] = 2'd0; ei[1] = 2'd1; ri0 = 2'd2;
            end
            3'b011:
            begin
                kind_next = tpc_pkg::KIND_TWO;
                si[0] = 2'd0; si[1] = 2'd1; ei[0] = 2'd2; ei[1] = 2'd2;
                ri0 = 2'd0; ri1 = 2'd1;
            end
            3'b101:
            begin
                kind_next = tpc_pkg::KIND_TWO;
                si[0] = 2'd0; si[1] = 2'd2; ei[0] = 2'd1; ei[1] = 2'd1;
                ri0 = 2'd0; ri1 = 2'd2;
            end
            3'b110:
            begin
                kind_next = tpc_pkg::KIND_TWO;
                si[0] = 2'd1; si[1] = 2'd2; ei[0] = 2'd0; ei[1] = 2'd0;
                ri0 = 2'd1; ri1 = 2'd2;
            end
        endcase

        for (int k = 0; k < 2; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                delta_next[k][c] = MW'(vert[ei[k]][c]) - MW'(vert[si[k]][c]);
            end
            den_next[k] = dval[si[k]] - dval[ei[k]];
        end
    end

    // Magnitude times start distance, split into low and high partial products
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag[k][c] = delta4_reg[k][c][MW-1] ? MW'(-delta4_reg[k][c])
                                                   : MW'(delta4_reg[k][c]);
                plo_next[k][c] = (MW+LO)'(mag[k][c]) * (MW+LO)'(ds4_reg[k][LO-1:0]);
                phi_next[k][c] = (MW+HI)'(mag[k][c]) * (MW+HI)'(ds4_reg[k][DSW-1:LO]);
                prod_next[k][c] = NW'(plo5_reg[k][c]) + (NW'(phi5_reg[k][c]) << LO);
            end
        end
    end

    // Advance the three stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind4_reg   <= kind_next;
            r4_reg[0]   <= vert[ri0];
            r4_reg[1]   <= vert[ri1];
            r4_reg[2]   <= vert[2];
            delta4_reg  <= delta_next;
            ds4_reg[0]  <= dval[si[0]][DSW-1:0];
            ds4_reg[1]  <= dval[si[1]][DSW-1:0];
            den4_reg    <= den_next;

            kind5_reg   <= kind4_reg;
            r5_reg      <= r4_reg;
            for (int k = 0; k < 2; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    neg5_reg[k][c] <= delta4_reg[k][c][MW-1];
                end
            end
            plo5_reg    <= plo_next;
            phi5_reg    <= phi_next;
            den5_reg    <= den4_reg;

            kind6_reg   <= kind5_reg;
            r6_reg      <= r5_reg;
            neg6_reg    <= neg5_reg;
            prod6_reg   <= prod_next;
            den6_reg    <= den5_reg;
        end
    end

    assign ctl.kind = kind6_reg;
    assign ctl.neg  = neg6_reg;
    assign rvert    = r6_reg;
    assign prod     = prod6_reg;
    assign den      = den6_reg;

endmodule

// ----- hdl/tpc_div.sv -----
// ----------------------------------------------------------------------------
// Intersection divider lane
// Pipelined restoring division of |E-S| * ds by (ds - de), a few quotient
// bits per stage, then a final stage that steps from S toward E.
// ----------------------------------------------------------------------------
module tpc_div #(
    parameter int CW = 32
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [2*CW+tpc_pkg::DIST_EXTRA-1:0] prod,
    input  logic [CW+tpc_pkg::DIST_EXTRA-1:0]   den,
    input  logic                                neg,
    input  logic signed [CW-1:0]                base,
    output logic signed [CW-1:0]                x
);

    localparam int MW    = CW + 1;
    localparam int DISTW = CW + tpc_pkg::DIST_EXTRA;
    localparam int DSW   = DISTW - 1;
    localparam int NW    = MW + DSW;
    localparam int NST   = (MW + tpc_pkg::DIV_STEPS - 1) / tpc_pkg::DIV_STEPS;

    logic [DISTW-1:0]     rem_s  [NST+1];
    logic [MW-1:0]        low_s  [NST+1];
    logic [DISTW-1:0]     den_s  [NST+1];
    logic                 neg_s  [NST+1];
    logic signed [CW-1:0] base_s [NST+1];
    logic signed [CW+1:0] x_next;
    logic signed [CW-1:0] x_reg;

    // Upper dividend bits start as the partial remainder, lower bits shift in
    assign rem_s[0]  = DISTW'(prod[NW-1:MW]);
    assign low_s[0]  = prod[MW-1:0];
    assign den_s[0]  = den;
    assign neg_s[0]  = neg;
    assign base_s[0] = base;

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        logic [DISTW-1:0]     rem_next;
        logic [MW-1:0]        low_next;
        logic [DISTW-1:0]     rem_reg;
        logic [MW-1:0]        low_reg;
        logic [DISTW-1:0]     den_reg;
        logic                 neg_reg;
        logic signed [CW-1:0] base_reg;

        // Resolve this stage's quotient bits
        always_comb
        begin
            logic [DISTW:0] trial;
            rem_next = rem_s[j];
            low_next = low_s[j];
            trial    = '0;
            for (int k = 0; k < tpc_pkg::DIV_STEPS; k++)
            begin
                if (j * tpc_pkg::DIV_STEPS + k < MW)
                begin
                    trial = {rem_next, low_next[MW-1]};
                    if (trial >= {1'b0, den_s[j]})
                    begin
                        trial    = trial - {1'b0, den_s[j]};
                        low_next = {low_next[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        low_next = {low_next[MW-2:0], 1'b0};
                    end
                    rem_next = trial[DISTW-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                low_reg  <= low_next;
                den_reg  <= den_s[j];
                neg_reg  <= neg_s[j];
                base_reg <= base_s[j];
            end
        end

        assign rem_s[j+1]  = rem_reg;
        assign low_s[j+1]  = low_reg;
        assign den_s[j+1]  = den_reg;
        assign neg_s[j+1]  = neg_reg;
        assign base_s[j+1] = base_reg;
    end

    // Step from the start vertex by the quotient, toward the end vertex
    always_comb
    begin
        if (neg_s[NST])
        begin
            x_next = (CW+2)'(base_s[NST]) - $signed((CW+2)'(low_s[NST]));
        end
        else
        begin
            x_next = (CW+2)'(base_s[NST]) + $signed((CW+2)'(low_s[NST]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next[CW-1:0];
        end
    end

    assign x = x_reg;

endmodule
